### rtl/core/mrf_pkg.sv
package mrf_pkg;

  localparam int MAX_WORDS   = 4;
  localparam int DATA_FIELDS = 4;
  localparam int WORD_LIMIT  = (MAX_WORDS < DATA_FIELDS) ? MAX_WORDS : DATA_FIELDS;

  localparam int LEN_SHORT   = 6;
  localparam int LEN_WM_BASE = 7;
  localparam int FRAME_MAX   = LEN_WM_BASE + 2 * WORD_LIMIT + 2;
  localparam int IDX_W       = $clog2(FRAME_MAX + 1);
  localparam int DW_IDX_W    = (DATA_FIELDS > 1) ? $clog2(DATA_FIELDS) : 1;

  localparam int POS_ADDR    = 0;
  localparam int POS_FC      = 1;
  localparam int POS_REG_HI  = 2;
  localparam int POS_REG_LO  = 3;
  localparam int POS_QTY_HI  = 4;
  localparam int POS_QTY_LO  = 5;
  localparam int POS_BCOUNT  = 6;

  localparam logic [7:0]  FC_READ         = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [7:0]  READ_QTY        = 8'h02;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  typedef enum logic [1:0] {
    OP_READ         = 2'd0,
    OP_WRITE_SINGLE = 2'd1,
    OP_WRITE_MULTI  = 2'd2,
    OP_RESERVED     = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic at_last;
  } dp_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/mrf_ctrl.sv
module mrf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_opcode,
  output logic                 in_stall,
  output mrf_pkg::dp_cmd_t     cmd,
  input  mrf_pkg::dp_status_t  status
);

  mrf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    cmd       = '0;
    unique case (state_r)
      mrf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (mrf_pkg::op_t'(in_opcode) != mrf_pkg::OP_RESERVED)) begin
          cmd.load  = 1'b1;
          state_nxt = mrf_pkg::ST_SEND;
        end
      end
      mrf_pkg::ST_SEND: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.at_last) begin
            state_nxt = mrf_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = mrf_pkg::ST_IDLE;
    endcase
  end

  a_send_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrf_pkg::ST_SEND) |-> in_stall)
    else $error("input taken while a frame is in progress");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.at_last) |=> (state_r == mrf_pkg::ST_IDLE))
    else $error("frame did not end after its last byte");

endmodule

### rtl/core/mrf_dp.sv
module mrf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mrf_pkg::dp_cmd_t     cmd,
  output mrf_pkg::dp_status_t  status,
  input  logic [1:0]           in_opcode,
  input  logic [7:0]           in_slave_address,
  input  logic [15:0]          in_register_address,
  input  logic [2:0]           in_word_count,
  input  logic [15:0]          in_data_word_0,
  input  logic [15:0]          in_data_word_1,
  input  logic [15:0]          in_data_word_2,
  input  logic [15:0]          in_data_word_3,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_frame_byte,
  output logic                 out_last_byte
);

  mrf_pkg::op_t                 op_r;
  logic [7:0]                   addr_r;
  logic [15:0]                  reg_r;
  logic [2:0]                   cnt_r;
  logic [15:0]                  data_r [mrf_pkg::DATA_FIELDS];
  logic [mrf_pkg::IDX_W-1:0]    idx_r;
  logic [15:0]                  crc_r;
  logic                         out_valid_r;
  logic [7:0]                   out_byte_r;
  logic                         out_last_r;

  logic [2:0]                   cnt_sat;
  logic [mrf_pkg::IDX_W-1:0]    dlen;
  logic [mrf_pkg::IDX_W-1:0]    data_off;
  logic [mrf_pkg::DW_IDX_W-1:0] word_sel;
  logic [15:0]                  word;
  logic                         is_data;
  logic [7:0]                   fc;
  logic [7:0]                   byte_sel;

  assign cnt_sat = (in_word_count > 3'(mrf_pkg::WORD_LIMIT)) ?
                   3'(mrf_pkg::WORD_LIMIT) : in_word_count;

  always_comb begin
    if (op_r == mrf_pkg::OP_WRITE_MULTI) begin
      dlen = mrf_pkg::IDX_W'(mrf_pkg::LEN_WM_BASE) + mrf_pkg::IDX_W'({cnt_r, 1'b0});
    end else begin
      dlen = mrf_pkg::IDX_W'(mrf_pkg::LEN_SHORT);
    end
  end

  assign is_data  = (idx_r < dlen);
  assign data_off = idx_r - mrf_pkg::IDX_W'(mrf_pkg::LEN_WM_BASE);
  assign word_sel = data_off[mrf_pkg::DW_IDX_W:1];
  assign word     = data_r[word_sel];

  always_comb begin
    case (op_r)
      mrf_pkg::OP_READ:         fc = mrf_pkg::FC_READ;
      mrf_pkg::OP_WRITE_SINGLE: fc = mrf_pkg::FC_WRITE_SINGLE;
      default:                  fc = mrf_pkg::FC_WRITE_MULTI;
    endcase
  end

  always_comb begin
    if (!is_data) begin
      byte_sel = (idx_r == dlen) ? crc_r[7:0] : crc_r[15:8];
    end else if (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_ADDR)) begin
      byte_sel = addr_r;
    end else if (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_FC)) begin
      byte_sel = fc;
    end else if (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_REG_HI)) begin
      byte_sel = reg_r[15:8];
    end else if (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_REG_LO)) begin
      byte_sel = reg_r[7:0];
    end else if (op_r == mrf_pkg::OP_READ) begin
      byte_sel = (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_QTY_HI)) ? 8'h00 : mrf_pkg::READ_QTY;
    end else if (op_r == mrf_pkg::OP_WRITE_SINGLE) begin
      byte_sel = (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_QTY_HI)) ?
                 data_r[0][15:8] : data_r[0][7:0];
    end else if (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_QTY_HI)) begin
      byte_sel = 8'h00;
    end else if (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_QTY_LO)) begin
      byte_sel = 8'({5'b0, cnt_r});
    end else if (idx_r == mrf_pkg::IDX_W'(mrf_pkg::POS_BCOUNT)) begin
      byte_sel = 8'({4'b0, cnt_r, 1'b0});
    end else begin
      byte_sel = data_off[0] ? word[7:0] : word[15:8];
    end
  end

  assign status.slot_free = !out_valid_r || !out_stall;
  assign status.at_last   = (idx_r == dlen + mrf_pkg::IDX_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= mrf_pkg::op_t'(in_opcode);
      addr_r    <= in_slave_address;
      reg_r     <= in_register_address;
      cnt_r     <= cnt_sat;
      data_r[0] <= in_data_word_0;
      data_r[1] <= in_data_word_1;
      data_r[2] <= in_data_word_2;
      data_r[3] <= in_data_word_3;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= '0;
      crc_r <= mrf_pkg::CRC_INIT;
    end else if (cmd.emit) begin
      idx_r <= idx_r + mrf_pkg::IDX_W'(1);
      if (is_data) begin
        crc_r <= mrf_pkg::crc_byte(crc_r, byte_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= status.at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  a_load_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (idx_r == '0 && crc_r == mrf_pkg::CRC_INIT))
    else $error("frame counter or crc not initialized on load");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.slot_free)
    else $error("byte emitted over an untaken output beat");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (idx_r <= dlen + mrf_pkg::IDX_W'(1)))
    else $error("byte index ran past the frame");

endmodule

### rtl/core/modbus_rtu_request_framer.sv
// Modbus RTU request framer: one accepted request beat yields a frame of 8 bytes
// (read, write single) or 9 + 2 * word count bytes (write multiple, at most 17),
// one byte per output beat, with out_last_byte set on the CRC high byte. Bytes
// leave one per cycle while out_stall is low, and the next request is taken once
// the last byte sits in the output register. The single byte-wide output
// register and the bytewise CRC-16 update set that rate. A request with the
// reserved opcode is taken and produces no bytes. Word counts above the limit
// are saturated.
module modbus_rtu_request_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_slave_address,
  input  logic [15:0] in_register_address,
  input  logic [2:0]  in_word_count,
  input  logic [15:0] in_data_word_0,
  input  logic [15:0] in_data_word_1,
  input  logic [15:0] in_data_word_2,
  input  logic [15:0] in_data_word_3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte
);

  mrf_pkg::dp_cmd_t    cmd;
  mrf_pkg::dp_status_t status;

  mrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .status    (status)
  );

  mrf_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_opcode           (in_opcode),
    .in_slave_address    (in_slave_address),
    .in_register_address (in_register_address),
    .in_word_count       (in_word_count),
    .in_data_word_0      (in_data_word_0),
    .in_data_word_1      (in_data_word_1),
    .in_data_word_2      (in_data_word_2),
    .in_data_word_3      (in_data_word_3),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_byte      (out_frame_byte),
    .out_last_byte       (out_last_byte)
  );

endmodule
